[design/device_presence_table_aging_macros.svh]
// Assertion macros for the presence table block.
// Used by the sequencer; define ASSERT_OFF to drop the checks.
`ifndef DEVICE_PRESENCE_TABLE_AGING_MACROS_SVH
`define DEVICE_PRESENCE_TABLE_AGING_MACROS_SVH

`ifndef ASSERT_OFF
`define DPTA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("presence table assertion failed");
`define DPTA_ASSERT_IMPL(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (pre) |-> (post)) \
    else $error("presence table assertion failed");
`else
`define DPTA_ASSERT(lbl, clk, rst, prop)
`define DPTA_ASSERT_IMPL(lbl, clk, rst, pre, post)
`endif

`endif

[design/dpta_pkg.sv]
// Shared types and constants for the presence table with aging.
// No dependencies; used by every module of the block.
package dpta_pkg;

  localparam int unsigned ENTRIES_DEF = 30;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned AGE_W       = 8;

  localparam logic [AGE_W-1:0] AGE_MAX       = 8'hff;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 8'd50;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_GET     = 2'd1,
    OP_TICK    = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  // one table entry as seen on the read side
  typedef struct packed {
    logic             online;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } entry_t;

  // write request into the table; index travels separately
  typedef struct packed {
    logic             en;
    logic             flag_we;
    logic             flag;
    logic             id_we;
    logic [ID_W-1:0]  id;
    logic             age_we;
    logic [AGE_W-1:0] age;
  } wr_t;

  // outcome of the per-entry compare / age unit
  typedef struct packed {
    logic             match;
    logic [AGE_W-1:0] age_inc;
    logic             expire;
  } eval_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] found_id;
  } res_t;

endpackage

[design/device_presence_table_aging.sv]
// Presence table with aging. One beat is taken only while the block is idle;
// it then walks the table one entry per cycle, busy until its result is taken.
// Get starts its walk at the iterator position; add/refresh stop on a hit.
// Async active-low reset empties the table, rewinds the iterator, limit = 50.
module device_presence_table_aging #(
  parameter int unsigned Entries = dpta_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,  // [15:0] dev_id
  input  logic [1:0]                  s_axis_tuser_i,  // [1:0] op
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [15:0]                 m_axis_tdata_o,  // [15:0] found_id
  output logic                        m_axis_tuser_o,  // [0] ok
  input  logic                        cfg_we_i,
  input  logic [7:0]                  cfg_wdata_i      // age_limit
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [dpta_pkg::AGE_W-1:0] limit_q;
  logic                       out_vld_q;
  dpta_pkg::res_t             out_q;

  logic                       start;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ready;
  dpta_pkg::res_t             res;
  logic                       rd_en;
  logic [IdxW-1:0]            rd_idx;
  dpta_pkg::entry_t           ent;
  logic [IdxW-1:0]            wr_idx;
  dpta_pkg::wr_t              wr;

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  assign res_ready       = !out_vld_q || m_axis_tready_i;

  dpta_ctrl #(
    .Entries (Entries)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (dpta_pkg::op_e'(s_axis_tuser_i)),
    .key_i       (s_axis_tdata_i),
    .limit_i     (limit_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .ent_i       (ent),
    .wr_idx_o    (wr_idx),
    .wr_o        (wr)
  );

  dpta_table #(
    .Entries (Entries)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .rd_o     (ent),
    .wr_idx_i (wr_idx),
    .wr_i     (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= dpta_pkg::AGE_LIMIT_RST;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (res_valid && res_ready) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output beat register, payload only
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.found_id;
  assign m_axis_tuser_o  = out_q.ok;

endmodule

[design/dpta_eval.sv]
// Shared per-entry unit: id compare, saturating age increment, limit compare.
// Depends on dpta_pkg.
module dpta_eval (
  input  dpta_pkg::entry_t                ent_i,
  input  logic [dpta_pkg::ID_W-1:0]       key_i,
  input  logic [dpta_pkg::AGE_W-1:0]      limit_i,
  output dpta_pkg::eval_t                 res_o
);

  logic [dpta_pkg::AGE_W-1:0] age_inc;

  always_comb begin
    if (ent_i.age == dpta_pkg::AGE_MAX) begin
      age_inc = ent_i.age;
    end else begin
      age_inc = ent_i.age + 1'b1;
    end
    res_o.match   = (ent_i.id == key_i);
    res_o.age_inc = age_inc;
    res_o.expire  = (age_inc > limit_i);
  end

endmodule

[design/dpta_table.sv]
// Entry storage: id and age memories with registered read, online and
// written flags in flops cleared by reset. Depends on dpta_pkg.
module dpta_table #(
  parameter  int unsigned Entries = dpta_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  output dpta_pkg::entry_t     rd_o,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  dpta_pkg::wr_t        wr_i
);

  logic [dpta_pkg::ID_W-1:0]  id_mem  [Entries];
  logic [dpta_pkg::AGE_W-1:0] age_mem [Entries];

  logic [Entries-1:0]         online_q;
  logic [Entries-1:0]         wrt_q;
  logic                       rd_online_q;
  logic                       rd_wrt_q;
  logic [dpta_pkg::ID_W-1:0]  rd_id_q;
  logic [dpta_pkg::AGE_W-1:0] rd_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q    <= '0;
      wrt_q       <= '0;
      rd_online_q <= 1'b0;
      rd_wrt_q    <= 1'b0;
    end else begin
      if (wr_i.en && wr_i.flag_we) begin
        online_q[wr_idx_i] <= wr_i.flag;
      end
      if (wr_i.en && wr_i.id_we) begin
        wrt_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_online_q <= online_q[rd_idx_i];
        rd_wrt_q    <= wrt_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.id_we) begin
      id_mem[wr_idx_i] <= wr_i.id;
    end
    if (wr_i.en && wr_i.age_we) begin
      age_mem[wr_idx_i] <= wr_i.age;
    end
    if (rd_en_i) begin
      rd_id_q  <= id_mem[rd_idx_i];
      rd_age_q <= age_mem[rd_idx_i];
    end
  end

  // an id never written reads as the reset value of zero
  assign rd_o.online = rd_online_q;
  assign rd_o.id     = rd_wrt_q ? rd_id_q : '0;
  assign rd_o.age    = rd_age_q;

endmodule

[design/dpta_ctrl.sv]
// Sequencer: walks the table one entry per cycle through the shared unit
// and issues write-backs. Depends on dpta_pkg, dpta_eval and the macro header.
`include "device_presence_table_aging_macros.svh"

module dpta_ctrl #(
  parameter  int unsigned Entries = dpta_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int unsigned CntW    = $clog2(Entries + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  dpta_pkg::op_e               op_i,
  input  logic [dpta_pkg::ID_W-1:0]   key_i,
  input  logic [dpta_pkg::AGE_W-1:0]  limit_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output dpta_pkg::res_t              res_o,
  output logic                        rd_en_o,
  output logic [IdxW-1:0]             rd_idx_o,
  input  dpta_pkg::entry_t            ent_i,
  output logic [IdxW-1:0]             wr_idx_o,
  output dpta_pkg::wr_t               wr_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  dpta_pkg::op_e               op_q, op_d;
  logic [dpta_pkg::ID_W-1:0]   key_q, key_d;
  logic [CntW-1:0]             rd_cnt_q, rd_cnt_d;
  logic                        ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]             ev_idx_q, ev_idx_d;
  logic [CntW-1:0]             scan_q, scan_d;
  logic [IdxW-1:0]             slot_q, slot_d;
  logic                        have_slot_q, have_slot_d;
  logic                        ok_q, ok_d;
  logic [dpta_pkg::ID_W-1:0]   found_q, found_d;

  dpta_pkg::eval_t             ev;
  dpta_pkg::wr_t               wr;

  dpta_eval u_eval (
    .ent_i   (ent_i),
    .key_i   (key_q),
    .limit_i (limit_i),
    .res_o   (ev)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    rd_cnt_d    = rd_cnt_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    scan_d      = scan_q;
    slot_d      = slot_q;
    have_slot_d = have_slot_q;
    ok_d        = ok_q;
    found_d     = found_q;
    rd_en_o     = 1'b0;
    rd_idx_o    = rd_cnt_q[IdxW-1:0];
    wr          = '0;
    wr_idx_o    = ev_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d        = op_i;
          key_d       = key_i;
          have_slot_d = 1'b0;
          ok_d        = 1'b0;
          found_d     = '0;
          rd_cnt_d    = (op_i == dpta_pkg::OP_GET) ? scan_q : '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // read stage
        if (rd_cnt_q < CntW'(Entries)) begin
          rd_en_o  = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_cnt_q[IdxW-1:0];
        end
        // evaluate stage, data from the previous read
        if (ev_vld_q) begin
          case (op_q)
            dpta_pkg::OP_ADD: begin
              if (!ent_i.online) begin
                slot_d      = ev_idx_q;
                have_slot_d = 1'b1;
              end
              if (ev.match) begin
                wr.en      = 1'b1;
                wr.flag_we = 1'b1;
                wr.flag    = 1'b1;
                wr.age_we  = 1'b1;
                ok_d       = 1'b1;
                state_d    = S_RESP;
              end
            end
            dpta_pkg::OP_GET: begin
              if (ent_i.online) begin
                ok_d    = 1'b1;
                found_d = ent_i.id;
                scan_d  = CntW'(ev_idx_q) + 1'b1;
                state_d = S_RESP;
              end
            end
            dpta_pkg::OP_TICK: begin
              if (ent_i.online) begin
                wr.en      = 1'b1;
                wr.age_we  = 1'b1;
                wr.age     = ev.age_inc;
                wr.flag_we = 1'b1;
                wr.flag    = !ev.expire;
              end
            end
            dpta_pkg::OP_REFRESH: begin
              if (ev.match) begin
                wr.en     = 1'b1;
                wr.age_we = 1'b1;
                state_d   = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
        // walk finished without an early hit
        if (!ev_vld_q && rd_cnt_q == CntW'(Entries)) begin
          if (op_q == dpta_pkg::OP_GET) begin
            scan_d = '0;
          end
          if (op_q == dpta_pkg::OP_ADD && have_slot_q) begin
            state_d = S_FILL;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_FILL: begin
        wr.en      = 1'b1;
        wr.flag_we = 1'b1;
        wr.flag    = 1'b1;
        wr.id_we   = 1'b1;
        wr.id      = key_q;
        wr.age_we  = 1'b1;
        wr_idx_o   = slot_q;
        ok_d       = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= dpta_pkg::OP_ADD;
      key_q       <= '0;
      rd_cnt_q    <= '0;
      ev_vld_q    <= 1'b0;
      ev_idx_q    <= '0;
      scan_q      <= '0;
      slot_q      <= '0;
      have_slot_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key_q       <= key_d;
      rd_cnt_q    <= rd_cnt_d;
      ev_vld_q    <= ev_vld_d;
      ev_idx_q    <= ev_idx_d;
      scan_q      <= scan_d;
      slot_q      <= slot_d;
      have_slot_q <= have_slot_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
    end
  end

  assign wr_o           = wr;
  assign idle_o         = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_RESP);
  assign res_o.ok       = ok_q;
  assign res_o.found_id = found_q;

  `DPTA_ASSERT(a_scan_in_range, clk_i, rst_ni, scan_q <= CntW'(Entries))
  `DPTA_ASSERT_IMPL(a_fill_has_slot, clk_i, rst_ni, state_q == S_FILL,
                    have_slot_q && op_q == dpta_pkg::OP_ADD)
  `DPTA_ASSERT_IMPL(a_write_when_busy, clk_i, rst_ni, wr.en,
                    state_q == S_SCAN || state_q == S_FILL)
  `DPTA_ASSERT_IMPL(a_start_when_idle, clk_i, rst_ni, start_i, state_q == S_IDLE)
  `DPTA_ASSERT(a_resp_held, clk_i, rst_ni,
               state_q == S_RESP && !res_ready_i |=>
               state_q == S_RESP && $stable(ok_q) && $stable(found_q))

endmodule

[verif/tb_device_presence_table_aging.sv]
`timescale 1ns / 100ps
// Self-checking bench for device_presence_table_aging: directed and random commands
// on the input stream, with replies predicted by a table model kept inside the bench.
// Depends on dpta_pkg and the block's RTL only.
module tb_device_presence_table_aging;

  localparam int unsigned NENT        = dpta_pkg::ENTRIES_DEF;
  localparam int unsigned WALK_CYCLES = NENT + 4;

  class presence_scoreboard;
    bit                         online[NENT];
    logic [dpta_pkg::ID_W-1:0]  ids[NENT];
    logic [dpta_pkg::AGE_W-1:0] ages[NENT];
    int unsigned                scan_pos;
    logic [dpta_pkg::AGE_W-1:0] limit;
    dpta_pkg::res_t             expected_replies[$];
    int unsigned                errors, replies_seen, adds_refused, scans_exhausted;
    int unsigned                revivals, expiries, saturations;

    function new();
      for (int i = 0; i < NENT; i++) begin
        online[i] = 1'b0;
        ids[i]    = '0;
        ages[i]   = '0;
      end
      scan_pos        = 0;
      limit           = dpta_pkg::AGE_LIMIT_RST;
      errors          = 0;
      replies_seen    = 0;
      adds_refused    = 0;
      scans_exhausted = 0;
      revivals        = 0;
      expiries        = 0;
      saturations     = 0;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // apply one accepted command to the table copy and queue its reply
    function void note_command(dpta_pkg::op_e op, logic [dpta_pkg::ID_W-1:0] id);
      dpta_pkg::res_t reply;
      int             slot;
      bit             have_slot;
      bit             hit;
      reply     = '0;
      slot      = 0;
      have_slot = 1'b0;
      hit       = 1'b0;
      case (op)
        dpta_pkg::OP_ADD: begin
          // last offline entry before a hit is the free slot
          for (int i = 0; i < NENT && !hit; i++) begin
            if (!online[i]) begin
              slot      = i;
              have_slot = 1'b1;
            end
            if (ids[i] == id) begin
              if (!online[i]) revivals++;
              online[i] = 1'b1;
              ages[i]   = '0;
              hit       = 1'b1;
            end
          end
          if (hit) begin
            reply.ok = 1'b1;
          end else if (have_slot) begin
            online[slot] = 1'b1;
            ids[slot]    = id;
            ages[slot]   = '0;
            reply.ok     = 1'b1;
          end else begin
            adds_refused++;
          end
        end
        dpta_pkg::OP_GET: begin
          for (int i = scan_pos; i < NENT && !hit; i++) begin
            if (online[i]) begin
              reply.ok       = 1'b1;
              reply.found_id = ids[i];
              scan_pos       = i + 1;
              hit            = 1'b1;
            end
          end
          if (!hit) begin
            scan_pos = 0;
            scans_exhausted++;
          end
        end
        dpta_pkg::OP_TICK: begin
          for (int i = 0; i < NENT; i++) begin
            if (online[i]) begin
              if (ages[i] == dpta_pkg::AGE_MAX) saturations++;
              else ages[i]++;
              if (ages[i] > limit) begin
                online[i] = 1'b0;
                expiries++;
              end
            end
          end
        end
        default: begin
          // refresh: first matching id only, online or not
          for (int i = 0; i < NENT && !hit; i++) begin
            if (ids[i] == id) begin
              ages[i] = '0;
              hit     = 1'b1;
            end
          end
        end
      endcase
      expected_replies.push_back(reply);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_reply(logic ok, logic [dpta_pkg::ID_W-1:0] found);
      dpta_pkg::res_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply beat with nothing outstanding", found, '0);
      end else begin
        want = expected_replies.pop_front();
        replies_seen++;
        if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
        if (found !== want.found_id) report_mismatch("found_id", found, want.found_id);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  presence_scoreboard sb;
  int unsigned        items_sent     = 0;
  int unsigned        limits_written = 0;
  int unsigned        burst_left     = 0;

  device_presence_table_aging #(
    .Entries(NENT)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reply side: check each accepted beat, stall in changing modes
  initial begin : reply_side
    int unsigned mode, mode_left, stall_left, cyc;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      cyc++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 99) < 70);
        2: m_tready <= (cyc % 5 == 2) || (cyc % 7 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else begin
            if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 24);
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // one command beat; valid stays up across a burst, drops for the gaps
  task automatic send_cmd(dpta_pkg::op_e op, logic [15:0] id);
    s_tuser  <= op;
    s_tdata  <= id;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_command(op, id);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
  endtask

  task automatic drain(int unsigned settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain(WALK_CYCLES);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.limit = v;
    limits_written++;
  endtask

  task automatic run_mix(int unsigned n_items, int unsigned tick_pct, int unsigned pool_n);
    logic [15:0]   pool[40];
    logic [15:0]   id;
    dpta_pkg::op_e op;
    int unsigned   r;
    pool[0] = 16'h0000;
    pool[1] = 16'hffff;
    for (int i = 2; i < 40; i++) pool[i] = 16'($urandom);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        op = dpta_pkg::OP_TICK;
      end else begin
        r  = $urandom_range(0, 99);
        op = (r < 45) ? dpta_pkg::OP_ADD :
             (r < 75) ? dpta_pkg::OP_GET : dpta_pkg::OP_REFRESH;
      end
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                       : pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 99) == 0) drain(0);
      send_cmd(op, id);
    end
  endtask

  // a few live entries, then enough ticks to drive their ages to the ceiling
  task automatic run_soak(int unsigned n_ticks);
    repeat (6) send_cmd(dpta_pkg::OP_ADD, 16'($urandom));
    repeat (n_ticks) begin
      if ($urandom_range(0, 9) == 0) send_cmd(dpta_pkg::OP_GET, 16'($urandom));
      send_cmd(dpta_pkg::OP_TICK, 16'($urandom));
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: scan runs dry, tick is harmless, refresh with and without a match
    send_cmd(dpta_pkg::OP_GET, 16'h0000);
    send_cmd(dpta_pkg::OP_TICK, 16'h0000);
    send_cmd(dpta_pkg::OP_REFRESH, 16'h1234);
    send_cmd(dpta_pkg::OP_REFRESH, 16'h0000);
    // id 0 hits the offline entries left by reset, so it revives one
    send_cmd(dpta_pkg::OP_ADD, 16'hffff);
    send_cmd(dpta_pkg::OP_ADD, 16'h0000);
    send_cmd(dpta_pkg::OP_ADD, 16'h8001);
    send_cmd(dpta_pkg::OP_ADD, 16'h7ffe);
    send_cmd(dpta_pkg::OP_ADD, 16'h5555);
    send_cmd(dpta_pkg::OP_ADD, 16'haaaa);
    send_cmd(dpta_pkg::OP_ADD, 16'h5555);
    repeat (8) send_cmd(dpta_pkg::OP_GET, 16'($urandom));
    send_cmd(dpta_pkg::OP_TICK, 16'hffff);
    send_cmd(dpta_pkg::OP_REFRESH, 16'hffff);
    send_cmd(dpta_pkg::OP_REFRESH, 16'hbeef);
    send_cmd(dpta_pkg::OP_TICK, 16'h0000);

    write_limit(8'd0);
    run_mix(170, 25, 12);
    write_limit(8'd255);
    run_soak(270);
    write_limit(8'd3);
    run_mix(170, 20, 20);
    write_limit(8'd254);
    run_soak(270);
    write_limit(8'($urandom_range(0, 255)));
    run_mix(170, 15, 24);
    write_limit(8'd1);
    run_mix(170, 30, 12);
    // rare ticks and a wide id pool so the table fills and adds get refused
    write_limit(8'd50);
    run_mix(220, 3, 40);
    write_limit(8'd12);
    run_mix(170, 12, 30);
    write_limit(8'($urandom_range(0, 255)));
    run_mix(170, 10, 40);

    drain(WALK_CYCLES + 8);
    $display("Run: %0d commands, %0d replies checked, %0d age limits written.",
             items_sent, sb.replies_seen, limits_written);
    $display("Seen: %0d refused adds, %0d dry scans, %0d revivals, %0d expiries, %0d capped.",
             sb.adds_refused, sb.scans_exhausted, sb.revivals, sb.expiries, sb.saturations);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8_400_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/dpta_pkg.sv
design/dpta_eval.sv
design/dpta_table.sv
design/dpta_ctrl.sv
design/device_presence_table_aging.sv
verif/tb_device_presence_table_aging.sv
